>>> design/i2cms_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
package i2cms_pkg;

  // Default outgoing buffer depth
  localparam int BUF_DEPTH_DEF = 256;

  // Channel widths (tdata payload bits padded to whole bytes)
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_EVENT = 2'd2
  } req_t;

  // Bus event codes
  typedef enum logic [2:0] {
    EV_START_SENT = 3'd0,
    EV_ADDR_TX    = 3'd1,
    EV_ADDR_RX    = 3'd2,
    EV_TX_EMPTY   = 3'd3,
    EV_BYTE_DONE  = 3'd4,
    EV_BYTE_RX    = 3'd5,
    EV_BUS_ERROR  = 3'd6,
    EV_OTHER      = 3'd7
  } ev_t;

  // Bus actions
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_ADDR  = 3'd2,
    ACT_DATA  = 3'd3,
    ACT_STOP  = 3'd4
  } act_t;

  // Transfer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_W_START  = 4'd1,
    PH_W_ADDR   = 4'd2,
    PH_W_DATA   = 4'd3,
    PH_R_START  = 4'd4,
    PH_R_ADDR   = 4'd5,
    PH_R_CMD    = 4'd6,
    PH_R_START2 = 4'd7,
    PH_R_ADDR2  = 4'd8,
    PH_R_DATA   = 4'd9
  } phase_t;

  // Handshake state: take an item, or wait for buffer read data
  typedef enum logic {
    CS_ACCEPT = 1'b0,
    CS_FETCH  = 1'b1
  } ctl_state_t;

  // Source of the bus byte in the result
  typedef enum logic [2:0] {
    BS_ZERO    = 3'd0,
    BS_WR_ADDR = 3'd1,
    BS_RD_ADDR = 3'd2,
    BS_COMMAND = 3'd3,
    BS_BUF     = 3'd4
  } byte_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      start_load;
    logic      buf_write;
    logic      buf_read;
    logic      count_inc;
    logic      res_load;
    act_t      act;
    byte_sel_t byte_sel;
    logic      rx_deliver;
    logic      done;
    logic      err;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cmd_mode;
    logic more_to_send;
    logic last_rx;
  } dp_status_t;

endpackage

>>> design/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer.
// Every accepted item gives exactly one result. A write-data step that sends
// a buffer byte first reads the buffer, then loads its result, as the buffer
// memory has a registered read port; no item is taken meanwhile. The result
// waits in an output register, and the next item is taken in the cycle that
// result is taken. Loads beyond BUF_DEPTH are dropped; the send position wraps
// at BUF_DEPTH. Buffer entries read before being loaded give undefined data.
module i2c_master_transfer_sequencer #(
  parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // buf_index, data_byte, dev_addr, command_byte, use_command, is_read,
  // xfer_length, event_code, zero pad
  input  logic [i2cms_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type
  input  logic [i2cms_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // bus_byte, rx_valid, rx_index, rx_byte, done_res, error, zero pad
  output logic [i2cms_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // action
  output logic [i2cms_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import i2cms_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic [2:0] action;
  logic [7:0] bus_byte;
  logic       rx_valid;
  logic [7:0] rx_index;
  logic [7:0] rx_byte;
  logic       done_res;
  logic       error;

  i2cms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser[1:0]),
    .event_code (in_tdata[43:41]),
    .is_read    (in_tdata[32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  i2cms_dpath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .buf_index    (in_tdata[7:0]),
    .data_byte    (in_tdata[15:8]),
    .dev_addr     (in_tdata[22:16]),
    .command_byte (in_tdata[30:23]),
    .use_command  (in_tdata[31]),
    .xfer_length  (in_tdata[40:33]),
    .action       (action),
    .bus_byte     (bus_byte),
    .rx_valid     (rx_valid),
    .rx_index     (rx_index),
    .rx_byte      (rx_byte),
    .done_res     (done_res),
    .error        (error)
  );

  // Result packing
  assign out_tdata = {5'd0, error, done_res, rx_byte, rx_index, rx_valid, bus_byte};
  assign out_tuser = action;

endmodule

>>> design/i2cms_ctrl.sv
// Controller: transfer phase machine and channel handshake.
module i2cms_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            req_type,
  input  logic [2:0]            event_code,
  input  logic                  is_read,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  i2cms_pkg::dp_status_t status,
  output i2cms_pkg::ctl_cmd_t   cmd
);
  import i2cms_pkg::*;

  phase_t     phase_r, phase_nxt;
  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_tready  = (state_r == CS_ACCEPT) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next phase and handshake state
  always_comb begin
    phase_nxt     = phase_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (state_r == CS_FETCH) begin
      state_nxt     = CS_ACCEPT;
      out_valid_nxt = 1'b1;
    end else if (in_fire) begin
      out_valid_nxt = 1'b1;
      case (req_type)
        REQ_START: begin
          if (phase_r == PH_IDLE) phase_nxt = is_read ? PH_R_START : PH_W_START;
        end
        REQ_EVENT: begin
          if (phase_r != PH_IDLE && event_code == EV_BUS_ERROR) begin
            phase_nxt = PH_IDLE;
          end else begin
            case (phase_r)
              PH_IDLE: phase_nxt = PH_IDLE;
              PH_W_START:
                phase_nxt = (event_code == EV_START_SENT) ? PH_W_ADDR : PH_IDLE;
              PH_W_ADDR: begin
                if (event_code == EV_ADDR_TX) begin
                  phase_nxt = PH_W_DATA;
                  if (!status.cmd_mode) begin
                    state_nxt     = CS_FETCH;
                    out_valid_nxt = 1'b0;
                  end
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end
              PH_W_DATA: begin
                if (event_code == EV_TX_EMPTY) begin
                  if (status.more_to_send) begin
                    state_nxt     = CS_FETCH;
                    out_valid_nxt = 1'b0;
                  end
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end
              PH_R_START:
                phase_nxt = (event_code == EV_START_SENT) ? PH_R_ADDR : PH_IDLE;
              PH_R_ADDR: begin
                if (status.cmd_mode && event_code == EV_ADDR_TX) phase_nxt = PH_R_CMD;
                else if (!status.cmd_mode && event_code == EV_ADDR_RX)
                  phase_nxt = PH_R_DATA;
                else phase_nxt = PH_IDLE;
              end
              PH_R_CMD:
                phase_nxt = (event_code == EV_BYTE_DONE) ? PH_R_START2 : PH_IDLE;
              PH_R_START2:
                phase_nxt = (event_code == EV_START_SENT) ? PH_R_ADDR2 : PH_IDLE;
              PH_R_ADDR2:
                phase_nxt = (event_code == EV_ADDR_RX) ? PH_R_DATA : PH_IDLE;
              PH_R_DATA: begin
                if (event_code != EV_BYTE_RX || status.last_rx) phase_nxt = PH_IDLE;
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd = '{start_load: 1'b0, buf_write: 1'b0, buf_read: 1'b0, count_inc: 1'b0,
            res_load: 1'b0, act: ACT_NONE, byte_sel: BS_ZERO, rx_deliver: 1'b0,
            done: 1'b0, err: 1'b0};
    if (state_r == CS_FETCH) begin
      // buffer byte now in the read register
      cmd.res_load = 1'b1;
      cmd.act      = ACT_DATA;
      cmd.byte_sel = BS_BUF;
    end else if (in_fire) begin
      cmd.res_load = 1'b1;
      case (req_type)
        REQ_LOAD: cmd.buf_write = 1'b1;
        REQ_START: begin
          if (phase_r != PH_IDLE) begin
            cmd.err = 1'b1;
          end else begin
            cmd.start_load = 1'b1;
            cmd.act        = ACT_START;
          end
        end
        REQ_EVENT: begin
          if (event_code == EV_BUS_ERROR) begin
            cmd.err = 1'b1;
          end else begin
            case (phase_r)
              PH_IDLE: cmd.err = 1'b0;
              PH_W_START: begin
                if (event_code == EV_START_SENT) begin
                  cmd.act      = ACT_ADDR;
                  cmd.byte_sel = BS_WR_ADDR;
                end else cmd.err = 1'b1;
              end
              PH_W_ADDR: begin
                if (event_code == EV_ADDR_TX) begin
                  if (status.cmd_mode) begin
                    cmd.act      = ACT_DATA;
                    cmd.byte_sel = BS_COMMAND;
                  end else begin
                    cmd.res_load  = 1'b0;
                    cmd.buf_read  = 1'b1;
                    cmd.count_inc = 1'b1;
                  end
                end else cmd.err = 1'b1;
              end
              PH_W_DATA: begin
                if (event_code == EV_TX_EMPTY) begin
                  if (status.more_to_send) begin
                    cmd.res_load  = 1'b0;
                    cmd.buf_read  = 1'b1;
                    cmd.count_inc = 1'b1;
                  end
                end else if (event_code == EV_BYTE_DONE) begin
                  cmd.act  = ACT_STOP;
                  cmd.done = 1'b1;
                end else cmd.err = 1'b1;
              end
              PH_R_START: begin
                if (event_code == EV_START_SENT) begin
                  cmd.act      = ACT_ADDR;
                  cmd.byte_sel = status.cmd_mode ? BS_WR_ADDR : BS_RD_ADDR;
                end else cmd.err = 1'b1;
              end
              PH_R_ADDR: begin
                if (status.cmd_mode && event_code == EV_ADDR_TX) begin
                  cmd.act      = ACT_DATA;
                  cmd.byte_sel = BS_COMMAND;
                end else if (!(!status.cmd_mode && event_code == EV_ADDR_RX)) begin
                  cmd.err = 1'b1;
                end
              end
              PH_R_CMD: begin
                if (event_code == EV_BYTE_DONE) cmd.act = ACT_START;
                else cmd.err = 1'b1;
              end
              PH_R_START2: begin
                if (event_code == EV_START_SENT) begin
                  cmd.act      = ACT_ADDR;
                  cmd.byte_sel = BS_RD_ADDR;
                end else cmd.err = 1'b1;
              end
              PH_R_ADDR2: begin
                if (event_code != EV_ADDR_RX) cmd.err = 1'b1;
              end
              PH_R_DATA: begin
                if (event_code == EV_BYTE_RX) begin
                  cmd.rx_deliver = 1'b1;
                  cmd.count_inc  = 1'b1;
                  if (status.last_rx) begin
                    cmd.act  = ACT_STOP;
                    cmd.done = 1'b1;
                  end
                end else cmd.err = 1'b1;
              end
              default: cmd.err = 1'b1;
            endcase
          end
        end
        default: cmd.err = 1'b0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      state_r     <= CS_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/i2cms_dpath.sv
// Datapath: transfer registers, outgoing buffer and result register.
module i2cms_dpath #(
  parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cms_pkg::ctl_cmd_t   cmd,
  output i2cms_pkg::dp_status_t status,
  input  logic [7:0]            buf_index,
  input  logic [7:0]            data_byte,
  input  logic [6:0]            dev_addr,
  input  logic [7:0]            command_byte,
  input  logic                  use_command,
  input  logic [7:0]            xfer_length,
  output logic [2:0]            action,
  output logic [7:0]            bus_byte,
  output logic                  rx_valid,
  output logic [7:0]            rx_index,
  output logic [7:0]            rx_byte,
  output logic                  done_res,
  output logic                  error
);
  import i2cms_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [8:0]    DEPTH_W = 9'(BUF_DEPTH);
  localparam logic [AW-1:0] POS_MAX = AW'(BUF_DEPTH - 1);

  // Transfer registers
  logic          cmd_mode_r;
  logic [6:0]    target_addr_r;
  logic [7:0]    saved_command_r;
  logic [7:0]    target_length_r;
  logic [7:0]    byte_count_r;
  logic [AW-1:0] pos_r;   // byte_count modulo buffer depth

  // Buffer
  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    rd_data_r;

  // Result register
  act_t          act_r;
  logic [7:0]    bus_byte_r;
  logic          rx_valid_r;
  logic [7:0]    rx_index_r;
  logic [7:0]    rx_byte_r;
  logic          done_r;
  logic          err_r;

  logic [8:0]    count_inc_w;
  logic [7:0]    byte_pick;
  logic          load_in_range;

  assign count_inc_w   = {1'b0, byte_count_r} + 9'd1;
  assign load_in_range = ({1'b0, buf_index} < DEPTH_W);

  assign status.cmd_mode     = cmd_mode_r;
  assign status.more_to_send = (byte_count_r < target_length_r);
  assign status.last_rx      = (count_inc_w >= {1'b0, target_length_r});

  // Transfer set-up and byte counting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_mode_r      <= 1'b0;
      target_addr_r   <= '0;
      saved_command_r <= '0;
      target_length_r <= '0;
      byte_count_r    <= '0;
      pos_r           <= '0;
    end else if (cmd.start_load) begin
      cmd_mode_r      <= use_command;
      target_addr_r   <= dev_addr;
      saved_command_r <= command_byte;
      target_length_r <= (xfer_length == 8'd0) ? 8'd1 : xfer_length;
      byte_count_r    <= '0;
      pos_r           <= '0;
    end else if (cmd.count_inc) begin
      byte_count_r <= count_inc_w[7:0];
      pos_r        <= (pos_r == POS_MAX) ? '0 : pos_r + AW'(1);
    end
  end

  // Buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.buf_write && load_in_range) mem[buf_index[AW-1:0]] <= data_byte;
    if (cmd.buf_read) rd_data_r <= mem[pos_r];
  end

  // Bus byte source
  always_comb begin
    case (cmd.byte_sel)
      BS_ZERO:    byte_pick = 8'd0;
      BS_WR_ADDR: byte_pick = {target_addr_r, 1'b0};
      BS_RD_ADDR: byte_pick = {target_addr_r, 1'b1};
      BS_COMMAND: byte_pick = saved_command_r;
      BS_BUF:     byte_pick = rd_data_r;
      default:    byte_pick = 8'd0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      act_r      <= cmd.act;
      bus_byte_r <= byte_pick;
      rx_valid_r <= cmd.rx_deliver;
      rx_index_r <= cmd.rx_deliver ? byte_count_r : 8'd0;
      rx_byte_r  <= cmd.rx_deliver ? data_byte : 8'd0;
      done_r     <= cmd.done;
      err_r      <= cmd.err;
    end
  end

  assign action   = act_r;
  assign bus_byte = bus_byte_r;
  assign rx_valid = rx_valid_r;
  assign rx_index = rx_index_r;
  assign rx_byte  = rx_byte_r;
  assign done_res = done_r;
  assign error    = err_r;

endmodule

>>> tb/sv/i2c_master_transfer_sequencer_tb.sv
// Self-checking testbench for the I2C master transfer sequencer: directed and random item streams.
module i2c_master_transfer_sequencer_tb;
  import i2cms_pkg::*;

  localparam int ITEM_TARGET    = 1750;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_LIMIT   = 10;

  // Input payload, lowest field in the lowest bits
  typedef struct packed {
    logic [3:0] pad;
    ev_t        event_code;
    logic [7:0] xfer_length;
    logic       is_read;
    logic       use_command;
    logic [7:0] command_byte;
    logic [6:0] dev_addr;
    logic [7:0] data_byte;
    logic [7:0] buf_index;
  } in_fields_t;

  // Result payload, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0] pad;
    logic       error;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       rx_valid;
    logic [7:0] bus_byte;
  } out_fields_t;

  typedef struct {
    act_t        action;
    out_fields_t fields;
  } bus_step_t;

  // Tracks the sequencer state and the bus steps still owed by the block
  class i2c_step_tracker;
    phase_t     phase;
    logic       cmd_mode;
    logic [6:0] target_addr;
    logic [7:0] saved_command;
    logic [7:0] target_length;
    logic [7:0] byte_count;
    logic [7:0] out_buffer [256];
    bus_step_t  awaited_steps [$];
    int         mismatches;

    function new();
      phase         = PH_IDLE;
      cmd_mode      = 1'b0;
      target_addr   = '0;
      saved_command = '0;
      target_length = '0;
      byte_count    = '0;
      mismatches    = 0;
    endfunction

    // Work out the bus step caused by one accepted item
    function void note_item(req_t req, in_fields_t f);
      bus_step_t  s;
      logic       abort;
      logic [7:0] wr_addr;
      logic [7:0] rd_addr;
      s.action = ACT_NONE;
      s.fields = '0;
      abort    = 1'b0;
      wr_addr  = {target_addr, 1'b0};
      rd_addr  = {target_addr, 1'b1};
      case (req)
        REQ_LOAD: begin
          out_buffer[f.buf_index] = f.data_byte;
        end
        REQ_START: begin
          if (phase != PH_IDLE) begin
            s.fields.error = 1'b1;
          end else begin
            cmd_mode      = f.use_command;
            target_addr   = f.dev_addr;
            saved_command = f.command_byte;
            target_length = (f.xfer_length == 8'd0) ? 8'd1 : f.xfer_length;
            byte_count    = 8'd0;
            phase         = f.is_read ? PH_R_START : PH_W_START;
            s.action      = ACT_START;
          end
        end
        REQ_EVENT: begin
          if (phase == PH_IDLE) begin
            if (f.event_code == EV_BUS_ERROR) s.fields.error = 1'b1;
          end else if (f.event_code == EV_BUS_ERROR) begin
            abort = 1'b1;
          end else begin
            case (phase)
              PH_W_START: begin
                if (f.event_code == EV_START_SENT) begin
                  s.action = ACT_ADDR;
                  s.fields.bus_byte = wr_addr;
                  phase = PH_W_ADDR;
                end else abort = 1'b1;
              end
              PH_W_ADDR: begin
                if (f.event_code == EV_ADDR_TX) begin
                  s.action = ACT_DATA;
                  if (cmd_mode) begin
                    s.fields.bus_byte = saved_command;
                  end else begin
                    s.fields.bus_byte = out_buffer[0];
                    byte_count = 8'd1;
                  end
                  phase = PH_W_DATA;
                end else abort = 1'b1;
              end
              PH_W_DATA: begin
                if (f.event_code == EV_TX_EMPTY) begin
                  // send the next buffer byte if any is left, else wait for the last byte to finish
                  if (byte_count < target_length) begin
                    s.action = ACT_DATA;
                    s.fields.bus_byte = out_buffer[byte_count];
                    byte_count = byte_count + 8'd1;
                  end
                end else if (f.event_code == EV_BYTE_DONE) begin
                  s.action = ACT_STOP;
                  s.fields.done_res = 1'b1;
                  phase = PH_IDLE;
                end else abort = 1'b1;
              end
              PH_R_START: begin
                if (f.event_code == EV_START_SENT) begin
                  s.action = ACT_ADDR;
                  s.fields.bus_byte = cmd_mode ? wr_addr : rd_addr;
                  phase = PH_R_ADDR;
                end else abort = 1'b1;
              end
              PH_R_ADDR: begin
                if (cmd_mode && f.event_code == EV_ADDR_TX) begin
                  s.action = ACT_DATA;
                  s.fields.bus_byte = saved_command;
                  phase = PH_R_CMD;
                end else if (!cmd_mode && f.event_code == EV_ADDR_RX) begin
                  phase = PH_R_DATA;
                end else abort = 1'b1;
              end
              PH_R_CMD: begin
                if (f.event_code == EV_BYTE_DONE) begin
                  s.action = ACT_START;
                  phase = PH_R_START2;
                end else abort = 1'b1;
              end
              PH_R_START2: begin
                if (f.event_code == EV_START_SENT) begin
                  s.action = ACT_ADDR;
                  s.fields.bus_byte = rd_addr;
                  phase = PH_R_ADDR2;
                end else abort = 1'b1;
              end
              PH_R_ADDR2: begin
                if (f.event_code == EV_ADDR_RX) phase = PH_R_DATA;
                else abort = 1'b1;
              end
              PH_R_DATA: begin
                if (f.event_code == EV_BYTE_RX) begin
                  s.fields.rx_valid = 1'b1;
                  s.fields.rx_index = byte_count;
                  s.fields.rx_byte  = f.data_byte;
                  byte_count = byte_count + 8'd1;
                  if (byte_count >= target_length) begin
                    s.action = ACT_STOP;
                    s.fields.done_res = 1'b1;
                    phase = PH_IDLE;
                  end
                end else abort = 1'b1;
              end
              default: abort = 1'b1;
            endcase
          end
          // unexpected event or bus error: drop the transfer
          if (abort) begin
            s.action = ACT_NONE;
            s.fields = '0;
            s.fields.error = 1'b1;
            phase = PH_IDLE;
          end
        end
        default: ;
      endcase
      awaited_steps.push_back(s);
    endfunction

    // Compare one accepted result with the oldest awaited step
    function void check_result(logic [2:0] act_bits, logic [31:0] data_bits);
      bus_step_t   e;
      out_fields_t got;
      logic        bad;
      got = data_bits;
      if (awaited_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: act %0d data %h", act_bits, data_bits);
        return;
      end
      e = awaited_steps.pop_front();
      bad = (act_bits != e.action) ||
            (got.bus_byte != e.fields.bus_byte) ||
            (got.rx_valid != e.fields.rx_valid) ||
            (got.rx_index != e.fields.rx_index) ||
            (got.rx_byte  != e.fields.rx_byte)  ||
            (got.done_res != e.fields.done_res) ||
            (got.error    != e.fields.error);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("mismatch: expected act %0d byte %h rxv %b idx %0d rx %h done %b err %b",
                   e.action, e.fields.bus_byte, e.fields.rx_valid, e.fields.rx_index,
                   e.fields.rx_byte, e.fields.done_res, e.fields.error);
          $display("          actual   act %0d byte %h rxv %b idx %0d rx %h done %b err %b",
                   act_bits, got.bus_byte, got.rx_valid, got.rx_index,
                   got.rx_byte, got.done_res, got.error);
        end
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  i2c_step_tracker tracker;
  bit              loaded_map [256];
  int              items_sent  = 0;
  int              ready_hold  = 0;
  int              quiet_count = 0;
  bit              burst_mode  = 1'b0;

  i2c_master_transfer_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stall length
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 12);
    return $urandom_range(20, 60);
  endfunction

  // Transfer length: mostly short, a few up to the maximum
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(0, 6));
    if (r < 97) return 8'($urandom_range(7, 40));
    if (r < 99) return 8'($urandom_range(0, 255));
    return 8'd255;
  endfunction

  function automatic in_fields_t rand_fields();
    in_fields_t  f;
    logic [63:0] raw;
    raw   = {$urandom, $urandom};
    f     = raw[IN_TDATA_W-1:0];
    f.pad = '0;
    return f;
  endfunction

  // Present one item and wait for its handshake
  task automatic send_item(req_t req, in_fields_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= f;
    do @(posedge clk); while (!in_tready);
    tracker.note_item(req, f);
    items_sent++;
    if (req == REQ_LOAD) loaded_map[f.buf_index] = 1'b1;
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] value);
    in_fields_t f;
    f = rand_fields();
    f.buf_index = idx;
    f.data_byte = value;
    send_item(REQ_LOAD, f);
  endtask

  task automatic send_event(ev_t code, logic [7:0] value);
    in_fields_t f;
    f = rand_fields();
    f.event_code = code;
    f.data_byte  = value;
    send_item(REQ_EVENT, f);
  endtask

  // A write may only send bytes that were loaded, so fill any gaps first
  task automatic send_start(logic [6:0] addr, logic [7:0] cmd, logic use_cmd, logic rd,
                            logic [7:0] len);
    in_fields_t f;
    int         n;
    n = (len == 8'd0) ? 1 : int'(len);
    if (!rd)
      for (int i = 0; i < n; i++)
        if (!loaded_map[i]) send_load(8'(i), 8'($urandom));
    f = rand_fields();
    f.dev_addr     = addr;
    f.command_byte = cmd;
    f.use_command  = use_cmd;
    f.is_read      = rd;
    f.xfer_length  = len;
    send_item(REQ_START, f);
  endtask

  // Hold the sender off until every awaited step has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.awaited_steps.size() != 0);
  endtask

  // Well-formed transfer with random content, optionally broken at one step
  task automatic run_transfer(logic use_cmd, logic rd, logic [7:0] len, logic broken);
    ev_t steps [$];
    int  n;
    int  brk;
    n = (len == 8'd0) ? 1 : int'(len);
    send_start(7'($urandom), 8'($urandom), use_cmd, rd, len);
    steps.push_back(EV_START_SENT);
    if (rd) begin
      if (use_cmd) begin
        steps.push_back(EV_ADDR_TX);
        steps.push_back(EV_BYTE_DONE);
        steps.push_back(EV_START_SENT);
      end
      steps.push_back(EV_ADDR_RX);
      repeat (n) steps.push_back(EV_BYTE_RX);
    end else begin
      steps.push_back(EV_ADDR_TX);
      repeat (use_cmd ? n : n - 1) steps.push_back(EV_TX_EMPTY);
      if ($urandom_range(0, 1)) steps.push_back(EV_TX_EMPTY);
      steps.push_back(EV_BYTE_DONE);
    end
    brk = broken ? $urandom_range(0, steps.size() - 1) : -1;
    foreach (steps[k]) begin
      // loads and rejected starts may land in the middle of a transfer
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) send_load(8'($urandom), 8'($urandom));
        else send_start(7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), pick_len());
      end
      if (k == brk) begin
        send_event(ev_t'($urandom_range(0, 7)), 8'($urandom));
        break;
      end
      send_event(steps[k], 8'($urandom));
    end
  endtask

  // Loose items of any kind
  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 2))
        0: send_load(8'($urandom), 8'($urandom));
        1: send_start(7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), pick_len());
        default: send_event(ev_t'($urandom_range(0, 7)), 8'($urandom));
      endcase
    end
  endtask

  // Receiver readiness: random stalls, none while in a burst
  always @(posedge clk) begin
    if (burst_mode) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_hold <= pick_stall();
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tuser, out_tdata);
  end

  // Watchdog: ends the run when nothing moves on either side for too long
  initial begin
    while (quiet_count < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_count = 0;
      else quiet_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin
    int r;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // buffer extremes
    send_load(8'd0, 8'hFF);
    send_load(8'd255, 8'h00);
    send_load(8'd1, 8'hA5);
    // events while idle: ignored, then bus error
    send_event(EV_OTHER, 8'h00);
    send_event(EV_BUS_ERROR, 8'hFF);
    // plain write, top address, zero length taken as one, idle transmit empty
    send_start(7'h7F, 8'h00, 1'b0, 1'b0, 8'd0);
    send_event(EV_START_SENT, 8'h00);
    send_event(EV_ADDR_TX, 8'h00);
    send_event(EV_TX_EMPTY, 8'h00);
    send_event(EV_BYTE_DONE, 8'h00);
    // command read with repeated start, start while busy rejected
    send_start(7'h00, 8'hFF, 1'b1, 1'b1, 8'd2);
    send_start(7'h7F, 8'h00, 1'b0, 1'b1, 8'd255);
    send_event(EV_START_SENT, 8'h00);
    send_event(EV_ADDR_TX, 8'h00);
    send_event(EV_BYTE_DONE, 8'h00);
    send_event(EV_START_SENT, 8'h00);
    send_event(EV_ADDR_RX, 8'h00);
    send_event(EV_BYTE_RX, 8'h00);
    send_event(EV_BYTE_RX, 8'hFF);
    // plain read aborted by an unexpected event
    send_start(7'h55, 8'h00, 1'b0, 1'b1, 8'd1);
    send_event(EV_START_SENT, 8'h00);
    send_event(EV_TX_EMPTY, 8'h00);
    // command write aborted by a bus error
    send_start(7'h2A, 8'h81, 1'b1, 1'b0, 8'd1);
    send_event(EV_BUS_ERROR, 8'h00);
    drain_results();

    // random part
    while (items_sent < ITEM_TARGET) begin
      burst_mode = ($urandom_range(0, 99) < 15);
      if (tracker.phase != PH_IDLE) send_event(EV_BUS_ERROR, 8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 75) run_transfer(1'($urandom), 1'($urandom), pick_len(),
                               $urandom_range(0, 99) < 20);
      else if (r < 90) run_noise();
      else repeat ($urandom_range(1, 8)) send_load(8'($urandom), 8'($urandom));
      if ($urandom_range(0, 49) == 0) drain_results();
    end

    burst_mode = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited_steps.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
